>>> hw/rtl/explicit_free_list_allocator_assert.svh
// ----------------------------------------------------------------------------
// Allocator assertion macros
// Shared property wrappers for the allocator checkers.
// ----------------------------------------------------------------------------
`ifndef EXPLICIT_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define EXPLICIT_FREE_LIST_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EFLA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("efla assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EFLA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("efla assertion failed");

`endif

>>> hw/rtl/efla_pkg.sv
// ----------------------------------------------------------------------------
// Allocator package
// Constants, beat types and tag helpers shared by the allocator modules.
// ----------------------------------------------------------------------------
package efla_pkg;

  localparam int HEAP_WORDS  = 4096;
  localparam int WORD_BYTES  = 8;
  localparam int WORD_W      = 16;
  localparam int IDX_W       = $clog2(HEAP_WORDS);
  localparam int BYTE_LSB    = $clog2(WORD_BYTES);
  localparam int ADDR_W      = 20;
  localparam int WALK_W      = IDX_W + 1;
  localparam int STORE_BYTES = HEAP_WORDS * WORD_BYTES;
  localparam int PAIR_BYTES  = 2 * WORD_BYTES;
  localparam int MIN_BLOCK   = 4 * WORD_BYTES;
  localparam int ALIGN_MASK  = 7;
  localparam int ALIGN_BYTES = 8;
  localparam int ALLOC_BIT   = 1;
  localparam int INIT_CHUNK  = 1 << 12;
  localparam int INIT_HEAD   = 4 * WORD_BYTES;
  localparam int INIT_TOP    = INIT_HEAD + INIT_CHUNK;
  localparam int CHUNK_RESET = 4096;

  localparam int PRO_HDR_IDX   = 1;
  localparam int PRO_FTR_IDX   = 2;
  localparam int CHUNK_HDR_IDX = (INIT_HEAD - WORD_BYTES) / WORD_BYTES;
  localparam int CHUNK_FTR_IDX = (INIT_TOP - PAIR_BYTES) / WORD_BYTES;
  localparam int EPI_IDX       = (INIT_TOP - WORD_BYTES) / WORD_BYTES;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [ADDR_W-1:0] waddr_t;

  typedef struct packed {
    logic        command;
    logic [15:0] request_size;
    logic [14:0] block_address;
  } efla_req_t;

  typedef struct packed {
    logic [14:0] payload_address;
    logic        success;
  } efla_rsp_t;

  typedef struct packed {
    logic   re;
    logic   we;
    waddr_t addr;
    word_t  wdata;
  } mem_req_t;

  function automatic waddr_t tag_size(input word_t w);
    tag_size = ADDR_W'(w & ~WORD_W'(ALIGN_MASK));
  endfunction

  function automatic word_t init_word(input logic [IDX_W-1:0] idx);
    word_t v;
    v = '0;
    case (idx)
      IDX_W'(PRO_HDR_IDX):   v = WORD_W'(PAIR_BYTES + ALLOC_BIT);
      IDX_W'(PRO_FTR_IDX):   v = WORD_W'(PAIR_BYTES + ALLOC_BIT);
      IDX_W'(CHUNK_HDR_IDX): v = WORD_W'(INIT_CHUNK);
      IDX_W'(CHUNK_FTR_IDX): v = WORD_W'(INIT_CHUNK);
      IDX_W'(EPI_IDX):       v = WORD_W'(ALLOC_BIT);
      default:               v = '0;
    endcase
    init_word = v;
  endfunction

endpackage

>>> hw/rtl/efla_heap_mem.sv
// ----------------------------------------------------------------------------
// Allocator heap store
// Single-port word store with byte addressing, range checking and an
// initialisation sweep that lays down the initial heap after reset.
// ----------------------------------------------------------------------------
module efla_heap_mem
  import efla_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output word_t    rdata_o,
  output logic     ready_o
);

  word_t             mem [HEAP_WORDS];
  logic [IDX_W-1:0]  clr_idx_q;
  logic              ready_q;
  logic              rvalid_q;
  word_t             rdata_q;
  logic              in_range;
  logic [IDX_W-1:0]  idx;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_idx;
  word_t             wr_data;

  assign in_range = req_i.addr < ADDR_W'(STORE_BYTES);
  assign idx      = req_i.addr[BYTE_LSB +: IDX_W];
  assign wr_en    = !ready_q || (req_i.we && in_range);
  assign wr_idx   = ready_q ? idx : clr_idx_q;
  assign wr_data  = ready_q ? req_i.wdata : init_word(clr_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      ready_q   <= 1'b0;
      rvalid_q  <= 1'b0;
    end else begin
      rvalid_q <= req_i.re && in_range;
      if (!ready_q) begin
        clr_idx_q <= clr_idx_q + 1'b1;
        if (clr_idx_q == '1) begin
          ready_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (req_i.re) begin
      rdata_q <= mem[idx];
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : '0;
  assign ready_o = ready_q;

endmodule

>>> hw/rtl/efla_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Walks the free list, grows the heap, splits, coalesces and relinks blocks
// through one read or write of the heap store per cycle.
// ----------------------------------------------------------------------------
module efla_ctrl
  import efla_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  efla_req_t req_i,
  input  word_t     chunk_i,
  input  logic      mem_ready_i,
  input  word_t     mem_rdata_i,
  output mem_req_t  mem_req_o,
  output logic      busy_o,
  output logic      done_o,
  output efla_rsp_t rsp_o
);

  localparam int STATE_W = 6;
  localparam logic [STATE_W-1:0] S_IDLE   = 6'd0;
  localparam logic [STATE_W-1:0] S_AL_0   = 6'd1;
  localparam logic [STATE_W-1:0] S_FF_CHK = 6'd2;
  localparam logic [STATE_W-1:0] S_FF_SZ  = 6'd3;
  localparam logic [STATE_W-1:0] S_FF_NX  = 6'd4;
  localparam logic [STATE_W-1:0] S_GR_CHK = 6'd5;
  localparam logic [STATE_W-1:0] S_GR_W0  = 6'd6;
  localparam logic [STATE_W-1:0] S_GR_W1  = 6'd7;
  localparam logic [STATE_W-1:0] S_GR_W2  = 6'd8;
  localparam logic [STATE_W-1:0] S_MG_0   = 6'd9;
  localparam logic [STATE_W-1:0] S_MG_1   = 6'd10;
  localparam logic [STATE_W-1:0] S_MG_2   = 6'd11;
  localparam logic [STATE_W-1:0] S_MG_3   = 6'd12;
  localparam logic [STATE_W-1:0] S_MG_4   = 6'd13;
  localparam logic [STATE_W-1:0] S_MG_5   = 6'd14;
  localparam logic [STATE_W-1:0] S_MG_U2  = 6'd15;
  localparam logic [STATE_W-1:0] S_MG_T0  = 6'd16;
  localparam logic [STATE_W-1:0] S_MG_T1  = 6'd17;
  localparam logic [STATE_W-1:0] S_UN_0   = 6'd18;
  localparam logic [STATE_W-1:0] S_UN_1   = 6'd19;
  localparam logic [STATE_W-1:0] S_UN_2   = 6'd20;
  localparam logic [STATE_W-1:0] S_UN_P   = 6'd21;
  localparam logic [STATE_W-1:0] S_UN_S   = 6'd22;
  localparam logic [STATE_W-1:0] S_UN_H   = 6'd23;
  localparam logic [STATE_W-1:0] S_PU_0   = 6'd24;
  localparam logic [STATE_W-1:0] S_PU_1   = 6'd25;
  localparam logic [STATE_W-1:0] S_PU_2   = 6'd26;
  localparam logic [STATE_W-1:0] S_PL_0   = 6'd27;
  localparam logic [STATE_W-1:0] S_PL_1   = 6'd28;
  localparam logic [STATE_W-1:0] S_PL_2   = 6'd29;
  localparam logic [STATE_W-1:0] S_PL_3   = 6'd30;
  localparam logic [STATE_W-1:0] S_PL_4   = 6'd31;
  localparam logic [STATE_W-1:0] S_PL_5   = 6'd32;
  localparam logic [STATE_W-1:0] S_PL_6   = 6'd33;
  localparam logic [STATE_W-1:0] S_FR_0   = 6'd34;
  localparam logic [STATE_W-1:0] S_FR_1   = 6'd35;
  localparam logic [STATE_W-1:0] S_FR_2   = 6'd36;
  localparam logic [STATE_W-1:0] S_FIN_OK = 6'd37;
  localparam logic [STATE_W-1:0] S_FIN_NG = 6'd38;

  logic [STATE_W-1:0] state_q, state_d;
  logic [STATE_W-1:0] unl_ret_q, unl_ret_d;
  logic [STATE_W-1:0] push_ret_q, push_ret_d;
  logic [STATE_W-1:0] merge_ret_q, merge_ret_d;
  logic               done_q, done_d;
  word_t              heap_top_q, heap_top_d;
  waddr_t             free_head_q, free_head_d;
  logic [WALK_W-1:0]  walk_q, walk_d;
  efla_rsp_t          rsp_q, rsp_d;

  logic   cmd_q, cmd_d;
  word_t  req_q, req_d;
  waddr_t bp_q, bp_d;
  waddr_t asize_q, asize_d;
  waddr_t size_q, size_d;
  waddr_t total_q, total_d;
  waddr_t pb_q, pb_d;
  waddr_t nb_q, nb_d;
  waddr_t psize_q, psize_d;
  waddr_t ux_q, ux_d;
  waddr_t px_q, px_d;
  word_t  lp_q, lp_d;
  word_t  ls_q, ls_d;
  logic   pa_q, pa_d;

  waddr_t rd_size;
  waddr_t ext;
  waddr_t grow_size;
  waddr_t top_w;
  logic   split;
  logic   free_ok;

  assign rd_size   = tag_size(mem_rdata_i);
  assign ext       = (asize_q > ADDR_W'(chunk_i)) ? asize_q : ADDR_W'(chunk_i);
  assign grow_size = (ext + ADDR_W'(WORD_BYTES)) & ~ADDR_W'(PAIR_BYTES - 1);
  assign top_w     = ADDR_W'(heap_top_q);
  assign split     = (total_q >= asize_q) && ((total_q - asize_q) >= ADDR_W'(MIN_BLOCK));
  assign free_ok   = (bp_q[BYTE_LSB-1:0] == '0) && (bp_q >= ADDR_W'(MIN_BLOCK))
                   && mem_rdata_i[0] && (rd_size >= ADDR_W'(MIN_BLOCK))
                   && (bp_q <= top_w) && (rd_size <= top_w - bp_q);

  always_comb begin
    state_d     = state_q;
    unl_ret_d   = unl_ret_q;
    push_ret_d  = push_ret_q;
    merge_ret_d = merge_ret_q;
    done_d      = 1'b0;
    heap_top_d  = heap_top_q;
    free_head_d = free_head_q;
    walk_d      = walk_q;
    rsp_d       = rsp_q;
    cmd_d       = cmd_q;
    req_d       = req_q;
    bp_d        = bp_q;
    asize_d     = asize_q;
    size_d      = size_q;
    total_d     = total_q;
    pb_d        = pb_q;
    nb_d        = nb_q;
    psize_d     = psize_q;
    ux_d        = ux_q;
    px_d        = px_q;
    lp_d        = lp_q;
    ls_d        = ls_q;
    pa_d        = pa_q;
    mem_req_o   = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i && mem_ready_i) begin
          cmd_d   = req_i.command;
          req_d   = req_i.request_size;
          bp_d    = ADDR_W'(req_i.block_address);
          state_d = (req_i.command == CMD_FREE) ? S_FR_0 : S_AL_0;
        end
      end
      S_AL_0: begin
        if (req_q == '0) begin
          state_d = S_FIN_NG;
        end else begin
          if (req_q <= WORD_W'(PAIR_BYTES)) begin
            asize_d = ADDR_W'(MIN_BLOCK);
          end else begin
            asize_d = (ADDR_W'(req_q) + ADDR_W'(PAIR_BYTES + ALIGN_BYTES - 1))
                    & ~ADDR_W'(ALIGN_MASK);
          end
          bp_d    = free_head_q;
          walk_d  = '0;
          state_d = S_FF_CHK;
        end
      end
      S_FF_CHK: begin
        if (bp_q == '0 || walk_q == WALK_W'(HEAP_WORDS)) begin
          size_d  = grow_size;
          state_d = S_GR_CHK;
        end else begin
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = bp_q - ADDR_W'(WORD_BYTES);
          state_d        = S_FF_SZ;
        end
      end
      S_FF_SZ: begin
        if (rd_size >= asize_q) begin
          state_d = S_PL_0;
        end else begin
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = bp_q + ADDR_W'(WORD_BYTES);
          state_d        = S_FF_NX;
        end
      end
      S_FF_NX: begin
        bp_d    = ADDR_W'(mem_rdata_i);
        walk_d  = walk_q + 1'b1;
        state_d = S_FF_CHK;
      end
      S_GR_CHK: begin
        if (top_w > ADDR_W'(STORE_BYTES) || size_q > ADDR_W'(STORE_BYTES) - top_w) begin
          state_d = S_FIN_NG;
        end else begin
          bp_d       = top_w;
          heap_top_d = heap_top_q + size_q[WORD_W-1:0];
          state_d    = S_GR_W0;
        end
      end
      S_GR_W0: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = bp_q - ADDR_W'(WORD_BYTES);
        mem_req_o.wdata = size_q[WORD_W-1:0];
        state_d         = S_GR_W1;
      end
      S_GR_W1: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = bp_q + size_q - ADDR_W'(PAIR_BYTES);
        mem_req_o.wdata = size_q[WORD_W-1:0];
        state_d         = S_GR_W2;
      end
      S_GR_W2: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = bp_q + size_q - ADDR_W'(WORD_BYTES);
        mem_req_o.wdata = WORD_W'(ALLOC_BIT);
        merge_ret_d     = S_PL_0;
        state_d         = S_MG_0;
      end
      S_MG_0: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = bp_q - ADDR_W'(PAIR_BYTES);
        state_d        = S_MG_1;
      end
      S_MG_1: begin
        pb_d           = bp_q - rd_size;
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = bp_q - rd_size - ADDR_W'(WORD_BYTES);
        state_d        = S_MG_2;
      end
      S_MG_2: begin
        psize_d        = rd_size;
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = pb_q + rd_size - ADDR_W'(PAIR_BYTES);
        state_d        = S_MG_3;
      end
      S_MG_3: begin
        pa_d           = mem_rdata_i[0];
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = bp_q - ADDR_W'(WORD_BYTES);
        state_d        = S_MG_4;
      end
      S_MG_4: begin
        size_d         = rd_size;
        nb_d           = bp_q + rd_size;
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = bp_q + rd_size - ADDR_W'(WORD_BYTES);
        state_d        = S_MG_5;
      end
      S_MG_5: begin
        case ({pa_q, mem_rdata_i[0]})
          2'b10: begin
            size_d    = size_q + rd_size;
            ux_d      = nb_q;
            unl_ret_d = S_MG_T0;
            state_d   = S_UN_0;
          end
          2'b01: begin
            bp_d      = pb_q;
            size_d    = size_q + psize_q;
            ux_d      = pb_q;
            unl_ret_d = S_MG_T0;
            state_d   = S_UN_0;
          end
          2'b00: begin
            size_d    = size_q + psize_q + rd_size;
            ux_d      = pb_q;
            unl_ret_d = S_MG_U2;
            state_d   = S_UN_0;
          end
          default: begin
            state_d = S_MG_T0;
          end
        endcase
      end
      S_MG_U2: begin
        ux_d      = nb_q;
        bp_d      = pb_q;
        unl_ret_d = S_MG_T0;
        state_d   = S_UN_0;
      end
      S_MG_T0: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = bp_q - ADDR_W'(WORD_BYTES);
        mem_req_o.wdata = size_q[WORD_W-1:0];
        state_d         = S_MG_T1;
      end
      S_MG_T1: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = bp_q + size_q - ADDR_W'(PAIR_BYTES);
        mem_req_o.wdata = size_q[WORD_W-1:0];
        px_d            = bp_q;
        push_ret_d      = merge_ret_q;
        state_d         = S_PU_0;
      end
      S_UN_0: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = ux_q;
        state_d        = S_UN_1;
      end
      S_UN_1: begin
        lp_d           = mem_rdata_i;
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = ux_q + ADDR_W'(WORD_BYTES);
        state_d        = S_UN_2;
      end
      S_UN_2: begin
        ls_d = mem_rdata_i;
        if (ux_q == free_head_q) begin
          free_head_d = ADDR_W'(mem_rdata_i);
          state_d     = (mem_rdata_i != '0) ? S_UN_H : unl_ret_q;
        end else if (lp_q != '0) begin
          state_d = S_UN_P;
        end else begin
          state_d = (mem_rdata_i != '0) ? S_UN_S : unl_ret_q;
        end
      end
      S_UN_P: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = ADDR_W'(lp_q) + ADDR_W'(WORD_BYTES);
        mem_req_o.wdata = ls_q;
        state_d         = (ls_q != '0) ? S_UN_S : unl_ret_q;
      end
      S_UN_S: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = ADDR_W'(ls_q);
        mem_req_o.wdata = lp_q;
        state_d         = unl_ret_q;
      end
      S_UN_H: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = ADDR_W'(ls_q);
        mem_req_o.wdata = '0;
        state_d         = unl_ret_q;
      end
      S_PU_0: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = px_q;
        mem_req_o.wdata = '0;
        state_d         = S_PU_1;
      end
      S_PU_1: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = px_q + ADDR_W'(WORD_BYTES);
        mem_req_o.wdata = free_head_q[WORD_W-1:0];
        state_d         = S_PU_2;
      end
      S_PU_2: begin
        mem_req_o.we    = free_head_q != '0;
        mem_req_o.addr  = free_head_q;
        mem_req_o.wdata = px_q[WORD_W-1:0];
        free_head_d     = px_q;
        state_d         = push_ret_q;
      end
      S_PL_0: begin
        if (bp_q == '0) begin
          state_d = S_FIN_NG;
        end else begin
          mem_req_o.re   = 1'b1;
          mem_req_o.addr = bp_q - ADDR_W'(WORD_BYTES);
          state_d        = S_PL_1;
        end
      end
      S_PL_1: begin
        total_d   = rd_size;
        ux_d      = bp_q;
        unl_ret_d = S_PL_2;
        state_d   = S_UN_0;
      end
      S_PL_2: begin
        mem_req_o.we   = 1'b1;
        mem_req_o.addr = bp_q - ADDR_W'(WORD_BYTES);
        if (split) begin
          mem_req_o.wdata = asize_q[WORD_W-1:0] | WORD_W'(ALLOC_BIT);
          state_d         = S_PL_3;
        end else begin
          mem_req_o.wdata = total_q[WORD_W-1:0] | WORD_W'(ALLOC_BIT);
          state_d         = S_PL_6;
        end
      end
      S_PL_3: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = bp_q + asize_q - ADDR_W'(PAIR_BYTES);
        mem_req_o.wdata = asize_q[WORD_W-1:0] | WORD_W'(ALLOC_BIT);
        state_d         = S_PL_4;
      end
      S_PL_4: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = bp_q + asize_q - ADDR_W'(WORD_BYTES);
        mem_req_o.wdata = total_q[WORD_W-1:0] - asize_q[WORD_W-1:0];
        state_d         = S_PL_5;
      end
      S_PL_5: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = bp_q + total_q - ADDR_W'(PAIR_BYTES);
        mem_req_o.wdata = total_q[WORD_W-1:0] - asize_q[WORD_W-1:0];
        px_d            = bp_q + asize_q;
        push_ret_d      = S_FIN_OK;
        state_d         = S_PU_0;
      end
      S_PL_6: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = bp_q + total_q - ADDR_W'(PAIR_BYTES);
        mem_req_o.wdata = total_q[WORD_W-1:0] | WORD_W'(ALLOC_BIT);
        state_d         = S_FIN_OK;
      end
      S_FR_0: begin
        mem_req_o.re   = 1'b1;
        mem_req_o.addr = bp_q - ADDR_W'(WORD_BYTES);
        state_d        = S_FR_1;
      end
      S_FR_1: begin
        if (free_ok) begin
          size_d          = rd_size;
          mem_req_o.we    = 1'b1;
          mem_req_o.addr  = bp_q - ADDR_W'(WORD_BYTES);
          mem_req_o.wdata = rd_size[WORD_W-1:0];
          state_d         = S_FR_2;
        end else begin
          state_d = S_FIN_NG;
        end
      end
      S_FR_2: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = bp_q + size_q - ADDR_W'(PAIR_BYTES);
        mem_req_o.wdata = size_q[WORD_W-1:0];
        merge_ret_d     = S_FIN_OK;
        state_d         = S_MG_0;
      end
      S_FIN_OK: begin
        done_d                = 1'b1;
        rsp_d.success         = 1'b1;
        rsp_d.payload_address = (cmd_q == CMD_ALLOC) ? bp_q[14:0] : '0;
        state_d               = S_IDLE;
      end
      S_FIN_NG: begin
        done_d                = 1'b1;
        rsp_d.success         = 1'b0;
        rsp_d.payload_address = '0;
        state_d               = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      unl_ret_q   <= S_IDLE;
      push_ret_q  <= S_IDLE;
      merge_ret_q <= S_IDLE;
      done_q      <= 1'b0;
      heap_top_q  <= WORD_W'(INIT_TOP);
      free_head_q <= ADDR_W'(INIT_HEAD);
      walk_q      <= '0;
    end else begin
      state_q     <= state_d;
      unl_ret_q   <= unl_ret_d;
      push_ret_q  <= push_ret_d;
      merge_ret_q <= merge_ret_d;
      done_q      <= done_d;
      heap_top_q  <= heap_top_d;
      free_head_q <= free_head_d;
      walk_q      <= walk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q   <= rsp_d;
    cmd_q   <= cmd_d;
    req_q   <= req_d;
    bp_q    <= bp_d;
    asize_q <= asize_d;
    size_q  <= size_d;
    total_q <= total_d;
    pb_q    <= pb_d;
    nb_q    <= nb_d;
    psize_q <= psize_d;
    ux_q    <= ux_d;
    px_q    <= px_d;
    lp_q    <= lp_d;
    ls_q    <= ls_d;
    pa_q    <= pa_d;
  end

  assign busy_o = (state_q != S_IDLE) || !mem_ready_i;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> hw/rtl/explicit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// Explicit free list allocator
// Boundary tag heap allocator with a first-fit LIFO free list in a word store.
// A zero-size allocate is rejected; an allocate walks the list from the head and
// grows the heap when no block fits; a free of an invalid block is rejected.
// One command is in flight at a time; the next is taken as the result shows.
// After reset the store is initialised word by word with busy held high.
// ----------------------------------------------------------------------------
module explicit_free_list_allocator
  import efla_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  efla_req_t req_i,
  output logic      done_o,
  output efla_rsp_t rsp_o,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  word_t     cfg_data_i
);

  word_t    chunk_q;
  mem_req_t mem_req;
  word_t    mem_rdata;
  logic     mem_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= WORD_W'(CHUNK_RESET);
    end else if (cfg_valid && cfg_ready) begin
      chunk_q <= cfg_data_i;
    end
  end

  efla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_i       (req_i),
    .chunk_i     (chunk_q),
    .mem_ready_i (mem_ready),
    .mem_rdata_i (mem_rdata),
    .mem_req_o   (mem_req),
    .busy_o      (busy),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  efla_heap_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata),
    .ready_o (mem_ready)
  );

endmodule

>>> hw/rtl/efla_checker.sv
// ----------------------------------------------------------------------------
// Allocator port checker
// Watches the command and result ports of the allocator over time.
// ----------------------------------------------------------------------------
`include "explicit_free_list_allocator_assert.svh"

module efla_checker
  import efla_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      done_o,
  input efla_rsp_t rsp_o
);

  `EFLA_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `EFLA_ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `EFLA_ASSERT_NEXT(a_no_instant_result, clk_i, rst_ni, start && !busy, !done_o)
  `EFLA_ASSERT_SAME(a_fail_no_addr, clk_i, rst_ni, done_o && !rsp_o.success, rsp_o.payload_address == '0)

endmodule

bind explicit_free_list_allocator efla_checker u_efla_checker (.*);

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Free list allocator testbench
// Drives allocate and free commands into the boundary tag allocator, predicts
// every response with an independent heap model kept in a scoreboard class,
// and compares each strobed response with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import efla_pkg::*;

  localparam int unsigned SIZE_MASK = 32'hFFFF_FFF8;
  localparam longint CYCLE_LIMIT = 100_000_000;

  class alloc_scoreboard;
    logic [15:0]  heap [HEAP_WORDS];
    int unsigned  top_byte;
    int unsigned  list_head;
    int unsigned  chunk;
    efla_rsp_t    pending_rsp [$];
    int unsigned  live [$];
    int unsigned  released [$];
    int           errors;

    function int unsigned word_at(int unsigned a);
      return (a / WORD_BYTES < HEAP_WORDS) ? heap[a / WORD_BYTES] : 0;
    endfunction

    function void put_word(int unsigned a, int unsigned v);
      if (a / WORD_BYTES < HEAP_WORDS) heap[a / WORD_BYTES] = v[15:0];
    endfunction

    function int unsigned blk_size(int unsigned bp);
      return word_at(bp - WORD_BYTES) & SIZE_MASK;
    endfunction

    function int unsigned prev_blk(int unsigned bp);
      return bp - (word_at(bp - PAIR_BYTES) & SIZE_MASK);
    endfunction

    function void mark(int unsigned bp, int unsigned sz, int unsigned used);
      put_word(bp - WORD_BYTES, sz | used);
      put_word(bp + sz - PAIR_BYTES, sz | used);
    endfunction

    function void push_head(int unsigned bp);
      put_word(bp, 0);
      put_word(bp + WORD_BYTES, list_head);
      if (list_head != 0) put_word(list_head, bp);
      list_head = bp;
    endfunction

    function void unlink(int unsigned bp);
      int unsigned p, s;
      p = word_at(bp);
      s = word_at(bp + WORD_BYTES);
      if (bp == list_head) begin
        list_head = s;
        if (s != 0) put_word(s, 0);
      end else begin
        if (p != 0) put_word(p + WORD_BYTES, s);
        if (s != 0) put_word(s, p);
      end
    endfunction

    function int unsigned coalesce(int unsigned bp);
      int unsigned pa, na, sz, p, n;
      p = prev_blk(bp);
      n = bp + blk_size(bp);
      pa = word_at(p + blk_size(p) - PAIR_BYTES) & ALLOC_BIT;
      na = word_at(n - WORD_BYTES) & ALLOC_BIT;
      sz = blk_size(bp);
      if (pa != 0 && na == 0) begin
        sz += blk_size(n);
        unlink(n);
      end else if (pa == 0 && na != 0) begin
        sz += blk_size(p);
        unlink(p);
        bp = p;
      end else if (pa == 0 && na == 0) begin
        sz += blk_size(p) + blk_size(n);
        unlink(p);
        unlink(n);
        bp = p;
      end
      mark(bp, sz, 0);
      push_head(bp);
      return bp;
    endfunction

    function int unsigned extend(int unsigned bytes);
      int unsigned words, sz, bp;
      words = bytes / WORD_BYTES;
      if (words[0]) words++;
      sz = words * WORD_BYTES;
      if (top_byte > STORE_BYTES || sz > STORE_BYTES - top_byte) return 0;
      bp = top_byte;
      top_byte += sz;
      mark(bp, sz, 0);
      put_word(bp + sz - WORD_BYTES, ALLOC_BIT);
      return coalesce(bp);
    endfunction

    function int unsigned search(int unsigned asize);
      int unsigned bp;
      bp = list_head;
      for (int n = 0; bp != 0 && n < HEAP_WORDS; n++) begin
        if (blk_size(bp) >= asize) return bp;
        bp = word_at(bp + WORD_BYTES);
      end
      return 0;
    endfunction

    function void carve(int unsigned bp, int unsigned asize);
      int unsigned total;
      total = blk_size(bp);
      unlink(bp);
      if (total >= asize && total - asize >= MIN_BLOCK) begin
        mark(bp, asize, ALLOC_BIT);
        mark(bp + asize, total - asize, 0);
        push_head(bp + asize);
      end else begin
        mark(bp, total, ALLOC_BIT);
      end
    endfunction

    function void clear_heap();
      foreach (heap[i]) heap[i] = '0;
      chunk = CHUNK_RESET;
      put_word(WORD_BYTES, PAIR_BYTES | ALLOC_BIT);
      put_word(2 * WORD_BYTES, PAIR_BYTES | ALLOC_BIT);
      put_word(3 * WORD_BYTES, ALLOC_BIT);
      top_byte = 4 * WORD_BYTES;
      list_head = 0;
      void'(extend(INIT_CHUNK));
      errors = 0;
    endfunction

    function void note_command(efla_req_t r);
      int unsigned asize, bp, h, sz, req;
      efla_rsp_t e;
      e = '0;
      req = r.request_size;
      bp = r.block_address;
      if (r.command == CMD_ALLOC) begin
        if (req != 0) begin
          asize = (req <= PAIR_BYTES) ? 2 * PAIR_BYTES
                : ((req + PAIR_BYTES + ALIGN_BYTES - 1) & SIZE_MASK);
          bp = search(asize);
          if (bp == 0) bp = extend((asize > chunk) ? asize : chunk);
          if (bp != 0) begin
            carve(bp, asize);
            e.payload_address = bp[14:0];
            e.success = 1'b1;
            live.push_back(bp);
          end
        end
      end else begin
        h = word_at(bp - WORD_BYTES);
        sz = h & SIZE_MASK;
        if ((bp & ALIGN_MASK) == 0 && bp >= 4 * WORD_BYTES && (h & ALLOC_BIT) != 0 &&
            sz >= MIN_BLOCK && bp <= top_byte && sz <= top_byte - bp) begin
          mark(bp, sz, 0);
          void'(coalesce(bp));
          e.success = 1'b1;
          foreach (live[i]) if (live[i] == bp) begin
            live.delete(i);
            break;
          end
          released.push_back(bp);
        end
      end
      pending_rsp.push_back(e);
    endfunction

    function void check_response(efla_rsp_t got);
      efla_rsp_t e;
      if (pending_rsp.size() == 0) begin
        $error("response with nothing expected: payload_address %0d success %0d",
               got.payload_address, got.success);
        errors++;
        return;
      end
      e = pending_rsp.pop_front();
      if (got.payload_address !== e.payload_address) begin
        $error("payload_address expected %0d actual %0d", e.payload_address,
               got.payload_address);
        errors++;
      end
      if (got.success !== e.success) begin
        $error("success expected %0d actual %0d", e.success, got.success);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i, rst_ni, start, busy, done_o, cfg_valid, cfg_ready;
  efla_req_t req_i;
  efla_rsp_t rsp_o;
  word_t     cfg_data_i;
  alloc_scoreboard sb;
  int        idle_pct;
  longint    cycles;

  explicit_free_list_allocator dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .done_o, .rsp_o,
    .cfg_valid, .cfg_ready, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_command(req_i);
      if (done_o) sb.check_response(rsp_o);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic issue(input logic cmd, input int unsigned req, input int unsigned addr);
    int gap;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    req_i.command = cmd;
    req_i.request_size = req[15:0];
    req_i.block_address = addr[14:0];
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start = 1'b0;
    while (sb.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_chunk(input int unsigned value);
    cfg_valid = 1'b1;
    cfg_data_i = value[15:0];
    do @(posedge clk_i); while (!cfg_ready);
    sb.chunk = value;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic random_item();
    int unsigned sel, sz, addr;
    sel = $urandom_range(99);
    addr = $urandom_range(32767);
    if (sel < 55 || sb.live.size() == 0) begin
      sel = $urandom_range(99);
      if (sel < 80) sz = $urandom_range(1, 256);
      else if (sel < 92) sz = $urandom_range(257, 4096);
      else if (sel < 97) sz = $urandom_range(4097, 32768);
      else if (sel < 98) sz = 0;
      else sz = $urandom_range(32769, 65535);
      issue(CMD_ALLOC, sz, addr);
    end else begin
      sel = $urandom_range(99);
      if (sel < 85) addr = sb.live[$urandom_range(sb.live.size() - 1)];
      else if (sel < 92 && sb.released.size() != 0)
        addr = sb.released[$urandom_range(sb.released.size() - 1)];
      issue(CMD_FREE, $urandom_range(65535), addr);
    end
  endtask

  initial begin
    int unsigned d [4];
    sb = new();
    sb.clear_heap();
    cycles = 0;
    idle_pct = 36;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_valid = 1'b0;
    cfg_data_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_chunk(CHUNK_RESET);
    issue(CMD_ALLOC, 0, 0);
    issue(CMD_ALLOC, 1, 32767);
    issue(CMD_ALLOC, 16, 0);
    issue(CMD_ALLOC, 17, 0);
    foreach (d[i]) begin
      issue(CMD_ALLOC, 40, 0);
      d[i] = sb.live[$];
    end
    issue(CMD_FREE, 0, d[1]);
    issue(CMD_FREE, 0, d[0]);
    issue(CMD_FREE, 0, d[3]);
    issue(CMD_FREE, 0, d[2]);
    issue(CMD_FREE, 0, d[2]);
    issue(CMD_FREE, 65535, 41);
    issue(CMD_FREE, 0, 8);
    issue(CMD_FREE, 0, 0);
    issue(CMD_FREE, 0, 32767);
    issue(CMD_ALLOC, 65535, 0);
    issue(CMD_ALLOC, 32768, 0);
    issue(CMD_ALLOC, 6000, 0);
    issue(CMD_ALLOC, 4000, 0);

    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: write_chunk(32);
        1: write_chunk(32768);
        default: write_chunk($urandom_range(32, 32768));
      endcase
      idle_pct = (phase == 0) ? 36 : (phase == 1) ? 81 : 0;
      repeat (617) random_item();
    end

    drain();
    if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
